@@ hw/rtl/atcl_pkg.sv @@
// Shared types, constants and helper functions for the AT command LED controller.
package atcl_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam logic [15:0] ANIM_PERIOD_RST = 16'd200;
    localparam int ADDR_W = 3;

    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_ECHO      = 4'd1;
    localparam logic [3:0] KIND_OK        = 4'd2;
    localparam logic [3:0] KIND_ERROR     = 4'd3;
    localparam logic [3:0] KIND_LED       = 4'd4;
    localparam logic [3:0] KIND_MODE      = 4'd5;
    localparam logic [3:0] KIND_TIME      = 4'd6;
    localparam logic [3:0] KIND_NOT_FOUND = 4'd7;
    localparam logic [3:0] KIND_EMPTY     = 4'd8;

    localparam logic [1:0] MODE_RIGHT = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_PINS  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [12:0] MASK_RST   = 13'h1000;
    localparam logic [12:0] MASK_WRAPR = 13'h0800;
    localparam logic [12:0] MASK_LOW   = 13'h0008;
    localparam logic [12:0] MASK_WRAPL = 13'h0010;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [55:0] STR_MODE = "AT+MODE";
    localparam logic [55:0] STR_TIME = "AT+TIME";
    localparam logic [47:0] STR_LED  = "AT+LED";

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] MAG_SAT   = 32'h8000_0001;

    typedef enum logic [2:0] {
        NUM_WS1,
        NUM_SIGN1,
        NUM_DIG1,
        NUM_WS2,
        NUM_SIGN2,
        NUM_DIG2,
        NUM_FAIL
    } num_state_t;

    typedef struct packed {
        logic        mode_ok;
        logic        led_ok;
        logic        time_ok;
        logic        blank;
        logic [7:0]  ch6;
        logic [7:0]  ch7;
        num_state_t  nstate;
        logic [31:0] mag1;
        logic        neg1;
        logic [31:0] mag2;
        logic        neg2;
    } line_info_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [31:0] acc_digit(input logic [31:0] mag, input logic [7:0] c);
        logic [35:0] t;
        t = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {32'd0, c[3:0]};
        if (t > {4'd0, MAG_LIMIT})
        begin
            return MAG_SAT;
        end
        return t[31:0];
    endfunction

endpackage

@@ hw/rtl/atcl_if.sv @@
// Valid/ready channel interfaces for items and results.
interface atcl_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface atcl_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         resp_kind;
    logic signed [31:0] resp_value;
    logic [7:0]         echo_byte;
    logic [12:0]        led_pins;

    modport source (output valid, output resp_kind, output resp_value, output echo_byte,
                    output led_pins, input ready);
    modport sink (input valid, input resp_kind, input resp_value, input echo_byte,
                  input led_pins, output ready);
endinterface

@@ hw/rtl/atcl_parser.sv @@
// Incremental line scanner: prefix matches, blank detection and number parsing.
module atcl_parser #(
    parameter int LINE_MAX = atcl_pkg::LINE_MAX_DEF,
    parameter int LEN_W    = $clog2(LINE_MAX + 2)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   clear,
    input  logic [7:0]             rx_byte,
    output atcl_pkg::line_info_t   info,
    output logic [LEN_W-1:0]       len
);

    atcl_pkg::line_info_t info_reg, info_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             store;
    logic             start;
    logic [2:0]       idx;
    atcl_pkg::num_state_t base;

    assign store = push && (len_reg < LEN_W'(LINE_MAX));
    assign idx   = len_reg[2:0];
    assign start = ((len_reg == LEN_W'(7)) && info_reg.led_ok && (info_reg.ch6 == atcl_pkg::CH_EQ))
        || ((len_reg == LEN_W'(8)) && info_reg.mode_ok && (info_reg.ch7 == atcl_pkg::CH_EQ));
    assign base  = start ? atcl_pkg::NUM_WS1 : info_reg.nstate;

    always_comb
    begin
        info_next = info_reg;
        len_next  = len_reg;
        if (clear)
        begin
            len_next          = '0;
            info_next.mode_ok = 1'b1;
            info_next.led_ok  = 1'b1;
            info_next.time_ok = 1'b1;
            info_next.blank   = 1'b1;
            info_next.nstate  = atcl_pkg::NUM_FAIL;
        end
        else if (push)
        begin
            if (len_reg <= LEN_W'(LINE_MAX))
            begin
                len_next = len_reg + LEN_W'(1);
            end
            if (store)
            begin
                if (len_reg < LEN_W'(7))
                begin
                    if (rx_byte != atcl_pkg::STR_MODE[8*(6-idx) +: 8])
                    begin
                        info_next.mode_ok = 1'b0;
                    end
                    if (rx_byte != atcl_pkg::STR_TIME[8*(6-idx) +: 8])
                    begin
                        info_next.time_ok = 1'b0;
                    end
                end
                if (len_reg < LEN_W'(6))
                begin
                    if (rx_byte != atcl_pkg::STR_LED[8*(5-idx) +: 8])
                    begin
                        info_next.led_ok = 1'b0;
                    end
                end
                if (len_reg == LEN_W'(6))
                begin
                    info_next.ch6 = rx_byte;
                end
                if (len_reg == LEN_W'(7))
                begin
                    info_next.ch7 = rx_byte;
                end
                if (!atcl_pkg::is_space(rx_byte))
                begin
                    info_next.blank = 1'b0;
                end
                info_next.nstate = atcl_pkg::NUM_FAIL;
                case (base)
                    atcl_pkg::NUM_WS1, atcl_pkg::NUM_WS2:
                    begin
                        if (atcl_pkg::is_space(rx_byte))
                        begin
                            info_next.nstate = base;
                            if (base == atcl_pkg::NUM_WS1) info_next.neg1 = 1'b0;
                            else info_next.neg2 = 1'b0;
                        end
                        else if ((rx_byte == atcl_pkg::CH_PLUS)
                            || (rx_byte == atcl_pkg::CH_MINUS))
                        begin
                            if (base == atcl_pkg::NUM_WS1)
                            begin
                                info_next.nstate = atcl_pkg::NUM_SIGN1;
                                info_next.neg1   = (rx_byte == atcl_pkg::CH_MINUS);
                            end
                            else
                            begin
                                info_next.nstate = atcl_pkg::NUM_SIGN2;
                                info_next.neg2   = (rx_byte == atcl_pkg::CH_MINUS);
                            end
                        end
                        else if (atcl_pkg::is_digit(rx_byte))
                        begin
                            if (base == atcl_pkg::NUM_WS1)
                            begin
                                info_next.nstate = atcl_pkg::NUM_DIG1;
                                info_next.neg1   = 1'b0;
                                info_next.mag1   = {28'd0, rx_byte[3:0]};
                            end
                            else
                            begin
                                info_next.nstate = atcl_pkg::NUM_DIG2;
                                info_next.neg2   = 1'b0;
                                info_next.mag2   = {28'd0, rx_byte[3:0]};
                            end
                        end
                    end
                    atcl_pkg::NUM_SIGN1:
                    begin
                        if (atcl_pkg::is_digit(rx_byte))
                        begin
                            info_next.nstate = atcl_pkg::NUM_DIG1;
                            info_next.mag1   = {28'd0, rx_byte[3:0]};
                        end
                    end
                    atcl_pkg::NUM_SIGN2:
                    begin
                        if (atcl_pkg::is_digit(rx_byte))
                        begin
                            info_next.nstate = atcl_pkg::NUM_DIG2;
                            info_next.mag2   = {28'd0, rx_byte[3:0]};
                        end
                    end
                    atcl_pkg::NUM_DIG1:
                    begin
                        if (atcl_pkg::is_digit(rx_byte))
                        begin
                            info_next.nstate = atcl_pkg::NUM_DIG1;
                            info_next.mag1   = atcl_pkg::acc_digit(info_reg.mag1, rx_byte);
                        end
                        else if (rx_byte == atcl_pkg::CH_COMMA)
                        begin
                            info_next.nstate = atcl_pkg::NUM_WS2;
                        end
                    end
                    atcl_pkg::NUM_DIG2:
                    begin
                        if (atcl_pkg::is_digit(rx_byte))
                        begin
                            info_next.nstate = atcl_pkg::NUM_DIG2;
                            info_next.mag2   = atcl_pkg::acc_digit(info_reg.mag2, rx_byte);
                        end
                    end
                    default:
                    begin
                        info_next.nstate = atcl_pkg::NUM_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            info_reg.mode_ok <= 1'b1;
            info_reg.led_ok  <= 1'b1;
            info_reg.time_ok <= 1'b1;
            info_reg.blank   <= 1'b1;
            info_reg.nstate  <= atcl_pkg::NUM_FAIL;
            info_reg.ch6     <= '0;
            info_reg.ch7     <= '0;
            info_reg.mag1    <= '0;
            info_reg.neg1    <= 1'b0;
            info_reg.mag2    <= '0;
            info_reg.neg2    <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            info_reg <= info_next;
        end
    end

    assign info = info_reg;
    assign len  = len_reg;

endmodule

@@ hw/rtl/at_command_led_controller.sv @@
// Top level of the AT command LED controller: command execution, LED animation, APB register.
//
// Channel | Role   | Payload
// item    | sink   | func, rx_byte
// result  | source | resp_kind, resp_value, echo_byte, led_pins
// APB     | slave  | anim_period at addresses 0 to 3 (paddr[2] low)
//
// Every item gives one result, registered on the transfer and valid in the cycle after it.
// A new item is taken every cycle while the result register is empty or being drained.
// A stalled result holds the block; line state only moves on an item transfer.
// Reset is asynchronous and returns to an empty line, no mode and mask 0x1000.
module at_command_led_controller #(
    parameter int LINE_MAX = atcl_pkg::LINE_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    atcl_item_if.sink                  item,
    atcl_result_if.source              result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [atcl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int LEN_W = $clog2(LINE_MAX + 2);

    logic [15:0]        period_reg;
    logic [12:0]        mask_reg, mask_next;
    logic [1:0]         mode_reg, mode_next;
    logic [1:0]         prev_reg, prev_next;
    logic [15:0]        down_reg, down_next;
    logic [31:0]        ticks_reg, ticks_next;
    logic               ovalid_reg;
    logic [3:0]         kind_reg, kind_next;
    logic [31:0]        value_reg, value_next;
    logic [7:0]         echo_reg, echo_next;
    logic               take;
    logic               is_byte;
    logic               line_end;
    logic               push;
    atcl_pkg::line_info_t info;
    logic [LEN_W-1:0]   len;
    logic               n1_mode, n1_led, s_ok;
    logic [3:0]         bit_idx;
    logic [12:0]        shifted;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? {16'd0, period_reg} : 32'd0;
    assign item.ready = !ovalid_reg || result.ready;
    assign take     = item.valid && item.ready;
    assign is_byte  = take && !item.func;
    assign line_end = is_byte && (item.rx_byte == atcl_pkg::CH_CR);
    assign push     = is_byte && (item.rx_byte != atcl_pkg::CH_CR) && (item.rx_byte != 8'd0);

    atcl_parser #(
        .LINE_MAX (LINE_MAX),
        .LEN_W    (LEN_W)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .clear   (line_end),
        .rx_byte (item.rx_byte),
        .info    (info),
        .len     (len)
    );

    assign n1_mode = (info.mag1 <= 32'd2) && (!info.neg1 || (info.mag1 == 32'd0));
    assign n1_led  = (info.mag1 >= 32'd5) && (info.mag1 <= 32'd12) && !info.neg1;
    assign s_ok    = (info.mag2 == 32'd0) || ((info.mag2 == 32'd1) && !info.neg2);
    assign bit_idx = info.mag1[3:0] - 4'd1;

    always_comb
    begin
        shifted = mask_reg;
        if (mode_reg == atcl_pkg::MODE_RIGHT)
        begin
            shifted = mask_reg >> 1;
            if ((shifted == atcl_pkg::MASK_LOW) || (shifted == 13'd0))
            begin
                shifted = atcl_pkg::MASK_WRAPR;
            end
        end
        else if (mode_reg == atcl_pkg::MODE_LEFT)
        begin
            shifted = mask_reg << 1;
            if (shifted == atcl_pkg::MASK_RST)
            begin
                shifted = atcl_pkg::MASK_WRAPL;
            end
            else if (shifted == 13'd0)
            begin
                shifted = atcl_pkg::MASK_WRAPR;
            end
        end
    end

    always_comb
    begin
        mask_next  = mask_reg;
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        down_next  = down_reg;
        ticks_next = ticks_reg;
        kind_next  = atcl_pkg::KIND_NONE;
        value_next = 32'd0;
        echo_next  = 8'd0;
        if (item.func)
        begin
            ticks_next = ticks_reg + 32'd1;
            if ((down_reg == 16'd0) || (mode_reg != prev_reg))
            begin
                down_next = period_reg;
                mask_next = shifted;
                prev_next = mode_reg;
            end
            else
            begin
                down_next = down_reg - 16'd1;
            end
        end
        else if (item.rx_byte != atcl_pkg::CH_CR)
        begin
            kind_next = atcl_pkg::KIND_ECHO;
            echo_next = item.rx_byte;
        end
        else if (len > LEN_W'(LINE_MAX))
        begin
            kind_next = atcl_pkg::KIND_NOT_FOUND;
        end
        else if (info.mode_ok && (len >= LEN_W'(7)))
        begin
            kind_next = atcl_pkg::KIND_NOT_FOUND;
            if ((len == LEN_W'(8)) && (info.ch7 == atcl_pkg::CH_QUERY))
            begin
                kind_next  = atcl_pkg::KIND_MODE;
                value_next = (mode_reg == atcl_pkg::MODE_NONE) ? 32'hFFFF_FFFF
                                                               : {30'd0, mode_reg};
            end
            else if ((len >= LEN_W'(8)) && (info.ch7 == atcl_pkg::CH_EQ)
                && (info.nstate == atcl_pkg::NUM_DIG1))
            begin
                if (n1_mode)
                begin
                    kind_next = atcl_pkg::KIND_OK;
                    mode_next = info.mag1[1:0];
                end
                else
                begin
                    kind_next = atcl_pkg::KIND_ERROR;
                end
            end
        end
        else if (info.led_ok && (len >= LEN_W'(6)) && (mode_reg == atcl_pkg::MODE_PINS))
        begin
            kind_next = atcl_pkg::KIND_NOT_FOUND;
            if ((len >= LEN_W'(7)) && (info.ch6 == atcl_pkg::CH_EQ))
            begin
                if (info.nstate == atcl_pkg::NUM_DIG1)
                begin
                    if (n1_led)
                    begin
                        kind_next  = atcl_pkg::KIND_LED;
                        value_next = {31'd0, mask_reg[bit_idx]};
                    end
                    else
                    begin
                        kind_next = atcl_pkg::KIND_ERROR;
                    end
                end
                else if (info.nstate == atcl_pkg::NUM_DIG2)
                begin
                    if (n1_led && s_ok)
                    begin
                        kind_next  = atcl_pkg::KIND_LED;
                        value_next = {31'd0, info.mag2[0]};
                        mask_next[bit_idx] = info.mag2[0];
                    end
                    else
                    begin
                        kind_next = atcl_pkg::KIND_ERROR;
                    end
                end
            end
        end
        else if (info.blank)
        begin
            kind_next = atcl_pkg::KIND_EMPTY;
        end
        else if (info.time_ok && (len == LEN_W'(7)))
        begin
            kind_next  = atcl_pkg::KIND_TIME;
            value_next = ticks_reg;
        end
        else
        begin
            kind_next = atcl_pkg::KIND_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= atcl_pkg::ANIM_PERIOD_RST;
            mask_reg   <= atcl_pkg::MASK_RST;
            mode_reg   <= atcl_pkg::MODE_NONE;
            prev_reg   <= atcl_pkg::MODE_NONE;
            down_reg   <= '0;
            ticks_reg  <= '0;
            ovalid_reg <= 1'b0;
            kind_reg   <= '0;
            value_reg  <= '0;
            echo_reg   <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr[2] == 1'b0))
            begin
                period_reg <= pwdata[15:0];
            end
            if (take)
            begin
                mask_reg   <= mask_next;
                mode_reg   <= mode_next;
                prev_reg   <= prev_next;
                down_reg   <= down_next;
                ticks_reg  <= ticks_next;
                kind_reg   <= kind_next;
                value_reg  <= value_next;
                echo_reg   <= echo_next;
                ovalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign result.valid      = ovalid_reg;
    assign result.resp_kind  = kind_reg;
    assign result.resp_value = value_reg;
    assign result.echo_byte  = echo_reg;
    assign result.led_pins   = mask_reg;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len <= LEN_W'(LINE_MAX + 1))
        else $error("Line length passed its limit.");

    a_echo_not_cr: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && (kind_reg == atcl_pkg::KIND_ECHO)) |-> (echo_reg != atcl_pkg::CH_CR))
        else $error("Carriage return was echoed.");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && (kind_reg != atcl_pkg::KIND_LED) && (kind_reg != atcl_pkg::KIND_MODE)
         && (kind_reg != atcl_pkg::KIND_TIME)) |-> (value_reg == 32'd0))
        else $error("Value set on a result kind that carries none.");
`endif

endmodule

@@ tb/at_command_led_controller_tb.sv @@
// Testbench for the AT command LED controller: directed lines, random command traffic and ticks.
`timescale 1ns / 100ps

module at_command_led_controller_tb;

    localparam int LINE_LIM = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] value;
        logic [7:0]         echo;
        logic [12:0]        pins;
    } answer_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [atcl_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    atcl_item_if item_ch ();
    atcl_result_if result_ch ();

    at_command_led_controller DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch.sink),
        .result(result_ch.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predicted state of the block.
    logic [15:0] period_shadow;
    logic [7:0]  line_buf [LINE_LIM];
    int          line_len;
    logic [12:0] mask_shadow;
    int          mode_shadow;
    int          prev_mode_shadow;
    logic [17:0] step_count;
    logic [31:0] tick_total;

    cmd_item_t pending_items[$];
    answer_t   expected_answers[$];
    int        error_count;
    int        idle_cycles;
    bit        in_taken;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        error_count++;
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    function automatic bit blank_char(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit line_prefix(input string lit);
        if (line_len < lit.len())
        begin
            return 1'b0;
        end
        for (int i = 0; i < lit.len(); i++)
        begin
            if (line_buf[i] != lit[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit parse_number(inout int pos, output int val);
        int p;
        longint mag;
        bit any;
        bit neg;
        p = pos;
        mag = 0;
        any = 1'b0;
        neg = 1'b0;
        val = 0;
        while (p < line_len && blank_char(line_buf[p]))
        begin
            p++;
        end
        if (p < line_len && (line_buf[p] == atcl_pkg::CH_PLUS
            || line_buf[p] == atcl_pkg::CH_MINUS))
        begin
            neg = line_buf[p] == atcl_pkg::CH_MINUS;
            p++;
        end
        while (p < line_len && line_buf[p] >= 8'h30 && line_buf[p] <= 8'h39)
        begin
            mag = mag * 10 + (line_buf[p] - 8'h30);
            if (mag > 64'h8000_0000)
            begin
                mag = 64'h8000_0001;
            end
            any = 1'b1;
            p++;
        end
        if (!any)
        begin
            return 1'b0;
        end
        if (neg)
        begin
            val = (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -int'(mag);
        end
        else
        begin
            val = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(mag);
        end
        pos = p;
        return 1'b1;
    endfunction

    function automatic logic [3:0] execute_line(output logic signed [31:0] value);
        int p;
        int n1;
        int n2;
        int i;
        value = 0;
        if (line_len > LINE_LIM)
        begin
            return atcl_pkg::KIND_NOT_FOUND;
        end
        if (line_prefix("AT+MODE"))
        begin
            if (line_len == 8 && line_buf[7] == atcl_pkg::CH_QUERY)
            begin
                value = mode_shadow;
                return atcl_pkg::KIND_MODE;
            end
            if (line_len >= 8 && line_buf[7] == atcl_pkg::CH_EQ)
            begin
                p = 8;
                if (parse_number(p, n1) && p == line_len)
                begin
                    if (n1 >= 0 && n1 <= 2)
                    begin
                        mode_shadow = n1;
                        return atcl_pkg::KIND_OK;
                    end
                    return atcl_pkg::KIND_ERROR;
                end
            end
            return atcl_pkg::KIND_NOT_FOUND;
        end
        if (line_prefix("AT+LED") && mode_shadow == 2)
        begin
            if (line_len < 7 || line_buf[6] != atcl_pkg::CH_EQ)
            begin
                return atcl_pkg::KIND_NOT_FOUND;
            end
            p = 7;
            if (!parse_number(p, n1))
            begin
                return atcl_pkg::KIND_NOT_FOUND;
            end
            if (p == line_len)
            begin
                if (n1 < 5 || n1 > 12)
                begin
                    return atcl_pkg::KIND_ERROR;
                end
                value = mask_shadow[n1 - 1];
                return atcl_pkg::KIND_LED;
            end
            if (line_buf[p] != atcl_pkg::CH_COMMA)
            begin
                return atcl_pkg::KIND_NOT_FOUND;
            end
            p++;
            if (!parse_number(p, n2) || p != line_len)
            begin
                return atcl_pkg::KIND_NOT_FOUND;
            end
            if ((n2 != 0 && n2 != 1) || n1 < 5 || n1 > 12)
            begin
                return atcl_pkg::KIND_ERROR;
            end
            mask_shadow[n1 - 1] = n2[0];
            value = n2;
            return atcl_pkg::KIND_LED;
        end
        for (i = 0; i < line_len; i++)
        begin
            if (!blank_char(line_buf[i]))
            begin
                break;
            end
        end
        if (i == line_len)
        begin
            return atcl_pkg::KIND_EMPTY;
        end
        if (line_len == 7 && line_prefix("AT+TIME"))
        begin
            value = tick_total;
            return atcl_pkg::KIND_TIME;
        end
        return atcl_pkg::KIND_NOT_FOUND;
    endfunction

    function automatic void step_mask();
        if (mode_shadow == 0)
        begin
            mask_shadow = mask_shadow >> 1;
            if (mask_shadow == atcl_pkg::MASK_LOW || mask_shadow == 13'd0)
            begin
                mask_shadow = atcl_pkg::MASK_WRAPR;
            end
        end
        else if (mode_shadow == 1)
        begin
            mask_shadow = mask_shadow << 1;
            if (mask_shadow == atcl_pkg::MASK_RST)
            begin
                mask_shadow = atcl_pkg::MASK_WRAPL;
            end
            else if (mask_shadow == 13'd0)
            begin
                mask_shadow = atcl_pkg::MASK_WRAPR;
            end
        end
    endfunction

    function automatic answer_t predict_answer(input cmd_item_t it);
        answer_t a;
        a = '0;
        if (it.func)
        begin
            tick_total++;
            if (step_count == 0 || mode_shadow != prev_mode_shadow)
            begin
                step_count = {2'b00, period_shadow};
                step_mask();
                prev_mode_shadow = mode_shadow;
            end
            else
            begin
                step_count--;
            end
        end
        else if (it.rx_byte == atcl_pkg::CH_CR)
        begin
            a.kind = execute_line(a.value);
            line_len = 0;
        end
        else
        begin
            a.kind = atcl_pkg::KIND_ECHO;
            a.echo = it.rx_byte;
            if (it.rx_byte != 8'd0)
            begin
                if (line_len < LINE_LIM)
                begin
                    line_buf[line_len] = it.rx_byte;
                end
                if (line_len <= LINE_LIM)
                begin
                    line_len++;
                end
            end
        end
        a.pins = mask_shadow;
        return a;
    endfunction

    function automatic int gap_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // Driver: offers the queued items with random gaps.
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                send_gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            end
            if (!item_ch.valid || in_taken)
            begin
                if (send_gap > 0 || pending_items.size() == 0)
                begin
                    if (send_gap > 0)
                    begin
                        send_gap--;
                    end
                    item_ch.valid <= 1'b0;
                end
                else
                begin
                    cmd_item_t it;
                    it = pending_items.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.func <= it.func;
                    item_ch.rx_byte <= it.rx_byte;
                end
            end
        end
    end

    // Receiver stalls, including one long hold-off.
    int stall_left;
    bit long_hold_armed;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_armed && pending_items.size() > 0 && pending_items.size() < 1200)
            begin
                long_hold_armed = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = gap_length();
                end
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles <= (item_ch.valid && item_ch.ready)
                || (result_ch.valid && result_ch.ready) ? 0 : idle_cycles + 1;
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    report("unexpected transfer", 32'(result_ch.resp_kind), 32'd0);
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (result_ch.resp_kind !== e.kind)
                        report("resp_kind", 32'(result_ch.resp_kind), 32'(e.kind));
                    if (result_ch.resp_value !== e.value)
                        report("resp_value", result_ch.resp_value, e.value);
                    if (result_ch.echo_byte !== e.echo)
                        report("echo_byte", 32'(result_ch.echo_byte), 32'(e.echo));
                    if (result_ch.led_pins !== e.pins)
                        report("led_pins", 32'(result_ch.led_pins), 32'(e.pins));
                end
            end
            in_taken = item_ch.valid && item_ch.ready;
            if (in_taken)
            begin
                expected_answers.push_back(predict_answer({item_ch.func, item_ch.rx_byte}));
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** at_command_led_controller: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [7:0] c);
        pending_items.push_back({1'b0, c});
    endtask

    task automatic push_line(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i]);
        end
        push_char(atcl_pkg::CH_CR);
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            pending_items.push_back({1'b1, 8'($urandom)});
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || item_ch.valid || expected_answers.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic write_period(input logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {16'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        period_shadow = v;
    endtask

    function automatic string random_number(input int hi);
        string s;
        int r;
        s = "";
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            s = " ";
        end
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            s = {s, "-"};
        end
        else if (r == 1)
        begin
            s = {s, "+"};
        end
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            s = {s, "99999999999"};
        end
        else
        begin
            s = {s, $sformatf("%0d", $urandom_range(0, hi))};
        end
        return s;
    endfunction

    function automatic string random_line();
        string s;
        int n;
        case ($urandom_range(0, 9))
            0: s = "AT+MODE?";
            1, 2: s = {"AT+MODE=", random_number(3)};
            3: s = "AT+TIME";
            4, 5, 6: s = {"AT+LED=", random_number(14), ",", random_number(2)};
            7: s = {"AT+LED=", random_number(14)};
            8:
            begin
                s = "";
                n = $urandom_range(0, 40);
                for (int i = 0; i < n; i++)
                begin
                    s = {s, string'(8'($urandom_range(1, 255)))};
                end
            end
            default:
            begin
                s = {"AT+LED=", random_number(14), "x"};
            end
        endcase
        return s;
    endfunction

    initial
    begin
        string s;
        error_count = 0;
        idle_cycles = 0;
        in_taken = 1'b0;
        send_gap = 0;
        stall_left = 0;
        long_hold_armed = 1'b1;
        period_shadow = atcl_pkg::ANIM_PERIOD_RST;
        line_len = 0;
        mask_shadow = atcl_pkg::MASK_RST;
        mode_shadow = -1;
        prev_mode_shadow = -1;
        step_count = 0;
        tick_total = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.func = 1'b0;
        item_ch.rx_byte = 8'd0;
        result_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_period(16'd0);
        push_line("AT+MODE?");
        push_line("AT+LED=5");
        push_line("");
        push_line(" \t");
        push_char(8'd0);
        push_char(8'hFF);
        push_line("AT+MODE=0");
        push_ticks(6);
        push_line("AT+MODE=1");
        push_ticks(6);
        push_line("AT+MODE=-2147483649");
        push_line("AT+MODE=2");
        push_line("AT+LED=12,1");
        push_line("AT+LED=4,1");
        push_line("AT+LED=7,2");
        push_line("AT+LED=7");
        push_line("AT+TIME");
        push_line("AT+TIMEAT+TIMEAT+TIMEAT+TIMEAT+TIME");
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_period(16'd1);
                1: write_period(16'hFFFF);
                2: write_period(16'($urandom_range(0, 20)));
                default: write_period(16'd0);
            endcase
            for (int k = 0; k < 35; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    push_ticks($urandom_range(1, 8));
                end
                else
                begin
                    s = random_line();
                    push_line(s);
                end
            end
            wait_drained();
        end
        if (error_count == 0)
        begin
            $display("** at_command_led_controller: PASSED **");
        end
        else
        begin
            $display("** at_command_led_controller: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/atcl_pkg.sv
hw/rtl/atcl_if.sv
hw/rtl/atcl_parser.sv
hw/rtl/at_command_led_controller.sv
tb/at_command_led_controller_tb.sv
